// ===== rtl/rapid_trigger_touch_qualifier_assert.svh =====
// assertion macros for the rapid trigger touch qualifier
`ifndef RAPID_TRIGGER_TOUCH_QUALIFIER_ASSERT_SVH
`define RAPID_TRIGGER_TOUCH_QUALIFIER_ASSERT_SVH

// checked on every edge outside reset
`define RTTQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rttq assertion failed");

// checked on every edge, reset included
`define RTTQ_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("rttq assertion failed");

`endif

// ===== rtl/rttq_pkg.sv =====
// shared constants and types of the rapid trigger touch qualifier
package rttq_pkg;

  localparam int CHANNELS  = 16;
  localparam int TIME_BITS = 32;

  localparam int CH_W      = 4;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BASE_W    = 16;
  localparam int TIME_IN_W = 32;
  localparam int DEV_W     = 18;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = 2 * BASE_W;

  // floor(p / 1000) = (p * RECIP) >> RECIP_SHIFT for every 32-bit p
  localparam int RECIP_SHIFT = 41;
  localparam logic [PROD_W-1:0] RECIP = 32'd2199023256;
  localparam int RPROD_W = 2 * PROD_W;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd100;
  localparam logic [CFG_W-1:0] WINDOW_RESET    = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_PERMILLE = 1'b0,
    CFG_WINDOW_MS          = 1'b1
  } cfg_idx_t;

  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic signed [DEV_W-1:0] dev_t;

  typedef struct packed {
    logic             active;
    logic             check;
    logic [DEV_W-1:0] diff;
  } track_res_t;

endpackage

// ===== rtl/rttq_if.sv =====
// sample and result channel interfaces
interface rttq_sample_if import rttq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CH_W-1:0]      channel;
  logic                 touched;
  logic [BASE_W-1:0]    baseline;
  logic [BASE_W-1:0]    raw_count;
  logic [TIME_IN_W-1:0] time_ms;

  modport source (output valid, channel, touched, baseline, raw_count, time_ms,
                  input ready);
  modport sink (input valid, channel, touched, baseline, raw_count, time_ms,
                output ready);
endinterface

interface rttq_result_if import rttq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            pressed;
  logic [CH_W-1:0] out_channel;

  modport source (output valid, pressed, out_channel, input ready);
  modport sink (input valid, pressed, out_channel, output ready);
endinterface

// ===== rtl/rapid_trigger_touch_qualifier.sv =====
// rapid trigger touch qualifier top level
// One result per sample, in sample order, registered through these stages:
// an input register that also holds the baseline times permille product,
// a stage that updates the per-channel peak and trough (read and written in
// the same cycle, so back-to-back samples of one channel see each other)
// and divides the product by 1000 through a reciprocal multiply, and an
// output register that applies the threshold. One sample can be accepted
// every cycle; a stalled result only holds the stages behind it once they
// are full. Configuration is written through cfg_we/cfg_index/cfg_data.
module rapid_trigger_touch_qualifier import rttq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  rttq_sample_if.sink          sample,
  rttq_result_if.source        result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "rapid_trigger_touch_qualifier_assert.svh"

  logic [CFG_W-1:0] threshold_permille;
  logic [CFG_W-1:0] window_ms;

  logic              s1_valid;
  logic [CH_W-1:0]   s1_channel;
  logic              s1_touched;
  dev_t              s1_dev;
  time_t             s1_now;
  logic [PROD_W-1:0] s1_prod;

  logic              s2_valid;
  logic [CH_W-1:0]   s2_channel;
  track_res_t        s2_res;
  logic [BASE_W-1:0] s2_quot;

  logic            out_valid;
  logic            out_pressed;
  logic [CH_W-1:0] out_channel;

  logic s1_free, s1_move, s2_free, s2_move, out_free, in_fire;
  track_res_t         trk_res;
  logic [RPROD_W-1:0] recip_prod;
  logic               released;

  assign out_free     = !out_valid || result.ready;
  assign s2_move      = s2_valid && out_free;
  assign s2_free      = !s2_valid || out_free;
  assign s1_move      = s1_valid && s2_free;
  assign s1_free      = !s1_valid || s2_free;
  assign sample.ready = s1_free;
  assign in_fire      = sample.valid && s1_free;

  assign result.valid       = out_valid;
  assign result.pressed     = out_pressed;
  assign result.out_channel = out_channel;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_permille <= THRESHOLD_RESET;
      window_ms          <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD_PERMILLE: threshold_permille <= cfg_data;
        CFG_WINDOW_MS:          window_ms          <= cfg_data;
      endcase
    end
  end

  rttq_track u_track (
    .clk       (clk),
    .rst       (rst),
    .upd       (s1_move),
    .channel   (s1_channel),
    .touched   (s1_touched),
    .dev       (s1_dev),
    .now       (s1_now),
    .window_ms (window_ms),
    .res       (trk_res)
  );

  assign recip_prod = RPROD_W'(s1_prod) * RPROD_W'(RECIP);
  assign released   = s2_res.check && (s2_res.diff > DEV_W'(s2_quot));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= sample.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_channel <= sample.channel;
      s1_touched <= sample.touched;
      s1_dev     <= $signed(DEV_W'(sample.raw_count)) - $signed(DEV_W'(sample.baseline));
      s1_now     <= TIME_BITS'(sample.time_ms);
      s1_prod    <= PROD_W'(sample.baseline) * PROD_W'(threshold_permille);
    end
    if (s1_move) begin
      s2_channel <= s1_channel;
      s2_res     <= trk_res;
      s2_quot    <= recip_prod[RECIP_SHIFT +: BASE_W];
    end
    if (s2_move) begin
      out_channel <= s2_channel;
      out_pressed <= s2_res.active && !released;
    end
  end

  `RTTQ_ASSERT(a_load_s1, sample.valid && sample.ready |=> s1_valid)
  `RTTQ_ASSERT(a_idle_not_pressed, s2_move && !s2_res.active |=> !out_pressed)
  `RTTQ_ASSERT(a_empty_ready, !s1_valid |-> sample.ready)
  `RTTQ_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !s1_valid && !s2_valid)

endmodule

// ===== rtl/rttq_track.sv =====
// per-channel peak and trough tracking with release check
module rttq_track import rttq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             upd,
  input  logic [CH_W-1:0]  channel,
  input  logic             touched,
  input  dev_t             dev,
  input  time_t            now,
  input  logic [CFG_W-1:0] window_ms,
  output track_res_t       res
);

  dev_t  peak_value   [CHANNELS];
  dev_t  trough_value [CHANNELS];
  time_t peak_time    [CHANNELS];
  time_t trough_time  [CHANNELS];
  logic [CHANNELS-1:0] rearm_pending;

  logic                in_range;
  logic [CH_IDX_W-1:0] idx;
  logic                rearm;
  dev_t                cur_pv, cur_tv, new_pv, new_tv;
  time_t               cur_pt, cur_tt, age_pt, age_tt, age_h, age_l, window;
  logic                upd_p, upd_t;
  logic signed [DEV_W:0] diff;

  assign in_range = {1'b0, channel} < (CH_W + 1)'(CHANNELS);
  assign idx      = channel[CH_IDX_W-1:0];
  assign window   = TIME_BITS'(window_ms);

  always_comb begin
    rearm  = rearm_pending[idx];
    cur_pv = rearm ? dev : peak_value[idx];
    cur_tv = rearm ? dev : trough_value[idx];
    cur_pt = rearm ? now : peak_time[idx];
    cur_tt = rearm ? now : trough_time[idx];
    age_pt = now - cur_pt;
    age_tt = now - cur_tt;
    upd_p  = (age_pt > window) || (dev > cur_pv);
    upd_t  = (age_tt > window) || (dev < cur_tv);
    new_pv = upd_p ? dev : cur_pv;
    new_tv = upd_t ? dev : cur_tv;
    age_h  = upd_p ? '0 : age_pt;
    age_l  = upd_t ? '0 : age_tt;
    if (age_h > age_l) begin
      diff = (DEV_W + 1)'(new_pv) - (DEV_W + 1)'(new_tv);
    end else begin
      diff = (DEV_W + 1)'(new_tv) - (DEV_W + 1)'(new_pv);
    end
    res.active = in_range && touched;
    res.check  = in_range && touched && (age_h != age_l) && (diff > 0);
    res.diff   = diff[DEV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rearm_pending <= '1;
    end else if (upd && in_range) begin
      rearm_pending[idx] <= !touched;
    end
  end

  always_ff @(posedge clk) begin
    if (upd && in_range && touched) begin
      peak_value[idx]   <= new_pv;
      trough_value[idx] <= new_tv;
      peak_time[idx]    <= upd_p ? now : cur_pt;
      trough_time[idx]  <= upd_t ? now : cur_tt;
    end
  end

endmodule

// ===== tb/rttq_checker.sv =====
// checker: predicts the qualified touch of every sample and compares it with the result stream
module rttq_checker import rttq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  rttq_sample_if               smp,
  rttq_result_if               res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   outstanding,
  output int                   checked,
  output int                   releases
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            pressed;
    logic [CH_W-1:0] channel;
  } verdict_t;

  logic [CFG_W-1:0] permille;
  logic [CFG_W-1:0] window;
  dev_t             peak_dev     [CHANNELS];
  dev_t             trough_dev   [CHANNELS];
  time_t            peak_stamp   [CHANNELS];
  time_t            trough_stamp [CHANNELS];
  logic             rearm        [CHANNELS];
  verdict_t         verdict_q[$];
  verdict_t         want;

  function automatic verdict_t qualify_touch(logic [CH_W-1:0] ch, logic tch,
                                             logic [BASE_W-1:0] base,
                                             logic [BASE_W-1:0] raw,
                                             time_t now);
    verdict_t          v;
    dev_t              d;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    int                delta;
    time_t             age_pk;
    time_t             age_tr;
    int                diff;
    v.channel = ch;
    v.pressed = 1'b0;
    if (int'(ch) < CHANNELS) begin
      if (!tch) begin
        rearm[ch] = 1'b1;
      end else begin
        d     = dev_t'(int'(raw) - int'(base));
        prod  = base * permille;
        quot  = prod / 32'd1000;
        delta = int'(quot[15:0]);
        if (rearm[ch]) begin
          rearm[ch]        = 1'b0;
          peak_dev[ch]     = d;
          trough_dev[ch]   = d;
          peak_stamp[ch]   = now;
          trough_stamp[ch] = now;
        end
        if (time_t'(now - peak_stamp[ch]) > {16'b0, window} || d > peak_dev[ch]) begin
          peak_dev[ch]   = d;
          peak_stamp[ch] = now;
        end
        if (time_t'(now - trough_stamp[ch]) > {16'b0, window} || d < trough_dev[ch]) begin
          trough_dev[ch]   = d;
          trough_stamp[ch] = now;
        end
        age_pk    = now - peak_stamp[ch];
        age_tr    = now - trough_stamp[ch];
        v.pressed = 1'b1;
        if (age_pk != age_tr) begin
          // older extreme minus newer extreme
          if (age_pk > age_tr) diff = int'(peak_dev[ch]) - int'(trough_dev[ch]);
          else diff = int'(trough_dev[ch]) - int'(peak_dev[ch]);
          if (diff > 0 && diff > delta) begin
            v.pressed = 1'b0;
            releases++;
          end
        end
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      permille = THRESHOLD_RESET;
      window   = WINDOW_RESET;
      for (int i = 0; i < CHANNELS; i++) rearm[i] = 1'b1;
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD_PERMILLE: permille = cfg_data;
          CFG_WINDOW_MS:          window   = cfg_data;
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        verdict_q.push_back(qualify_touch(smp.channel, smp.touched, smp.baseline,
                                          smp.raw_count, smp.time_ms));
      end
      if (res.valid && res.ready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: pressed=%0b channel=%0d",
                   $time, res.pressed, res.out_channel);
        end else begin
          want = verdict_q.pop_front();
          checked++;
          if (want.pressed !== res.pressed || want.channel !== res.out_channel) begin
            errors++;
            $display("%0t: expected pressed=%0b channel=%0d, actual pressed=%0b channel=%0d",
                     $time, want.pressed, want.channel, res.pressed, res.out_channel);
          end
        end
      end
    end
    outstanding = verdict_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// testbench top: clock, reset, sample stimulus, configuration phases and verdict
module tb import rttq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int          errors;
  int          outstanding;
  int          checked;
  int          releases;
  int          n_samples;
  int          n_settings;
  bit          quiet;
  logic [31:0] now_ms;
  logic [15:0] permille_cur;
  logic [15:0] window_cur;

  rttq_sample_if smp ();
  rttq_result_if res ();

  rapid_trigger_touch_qualifier u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rttq_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .smp         (smp),
    .res         (res),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .releases    (releases)
  );

  always #4 clk = ~clk;

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // one sample transaction; valid stays high on return
  task automatic put_sample(logic [CH_W-1:0] ch, logic tch, logic [BASE_W-1:0] base,
                            logic [BASE_W-1:0] raw, logic [31:0] stamp);
    smp.valid     <= 1'b1;
    smp.channel   <= ch;
    smp.touched   <= tch;
    smp.baseline  <= base;
    smp.raw_count <= raw;
    smp.time_ms   <= stamp;
    @(negedge clk);
    while (!smp.ready) @(negedge clk);
    @(posedge clk);
    n_samples++;
  endtask

  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      smp.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] thr, logic [15:0] win);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD_PERMILLE;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_MS;
    cfg_data  <= win;
    @(posedge clk);
    cfg_we       <= 1'b0;
    permille_cur = thr;
    window_cur   = win;
    n_settings++;
  endtask

  task automatic advance();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) now_ms += $urandom;
    else if (r < 5) now_ms += window_cur + $urandom_range(0, 2);
    else now_ms += $urandom_range(0, 6);
  endtask

  task automatic noise();
    put_sample(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 16'($urandom),
               16'($urandom), ($urandom_range(0, 7) == 0) ? 32'($urandom) : now_ms);
  endtask

  // optional untouched arm, then a random walk of mostly touched samples around the baseline
  task automatic touch_stroke();
    logic [CH_W-1:0]   ch;
    logic [BASE_W-1:0] base;
    logic [31:0]       prod;
    int                thr;
    int                stepsz;
    int                offset;
    int                level;
    int                len;
    int                k;
    ch     = CH_W'($urandom_range(0, CHANNELS - 1));
    base   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(200, 6000));
    prod   = base * permille_cur;
    thr    = int'((prod / 32'd1000) & 32'hFFFF);
    stepsz = (thr > 40000) ? 20000 : thr / 2 + 4;
    offset = 0;
    len    = $urandom_range(3, 14);
    if ($urandom_range(0, 3) != 0) begin
      maybe_pause();
      put_sample(ch, 1'b0, base, 16'($urandom), now_ms);
      advance();
    end
    for (k = 0; k < len; k++) begin
      offset += int'($urandom_range(0, 2 * stepsz)) - stepsz;
      level = int'(base) + offset;
      if (level < 0) level = 0;
      else if (level > 65535) level = 65535;
      maybe_pause();
      put_sample(ch, ($urandom_range(0, 19) != 0), base, 16'(level), now_ms);
      advance();
      if ($urandom_range(0, 4) == 0) begin
        maybe_pause();
        noise();
      end
    end
  endtask

  initial begin
    res.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        res.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    logic [15:0] thr_set [7];
    logic [15:0] win_set [7];
    int          phase_end;
    thr_set = '{16'd0, 16'd65535, 16'd1000, 16'd100, 16'd1, 16'($urandom), 16'd400};
    win_set = '{16'd0, 16'd65535, 16'd20, 16'd50, 16'd1, 16'($urandom), 16'd5};
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_THRESHOLD_PERMILLE;
    cfg_data      <= '0;
    smp.valid     <= 1'b0;
    smp.channel   <= '0;
    smp.touched   <= 1'b0;
    smp.baseline  <= '0;
    smp.raw_count <= '0;
    smp.time_ms   <= '0;
    permille_cur  = THRESHOLD_RESET;
    window_cur    = WINDOW_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // time zero, touch start, deviation extremes
    put_sample(4'd0, 1'b0, 16'd0, 16'd0, 32'd0);
    put_sample(4'd0, 1'b1, 16'd0, 16'd0, 32'd0);
    put_sample(4'd0, 1'b1, 16'd0, 16'd65535, 32'd1);
    put_sample(4'd3, 1'b1, 16'd65535, 16'd0, 32'd1);
    // rise, fall past the threshold, then expiry and rearm
    put_sample(4'd1, 1'b1, 16'd1000, 16'd1000, 32'd10);
    put_sample(4'd1, 1'b1, 16'd1000, 16'd1200, 32'd11);
    put_sample(4'd1, 1'b1, 16'd1000, 16'd1000, 32'd12);
    put_sample(4'd1, 1'b1, 16'd1000, 16'd900, 32'd13);
    put_sample(4'd1, 1'b1, 16'd1000, 16'd900, 32'd13);
    put_sample(4'd1, 1'b1, 16'd1000, 16'd900, 32'd64);
    put_sample(4'd1, 1'b0, 16'd1000, 16'd900, 32'd65);
    // release across the time wrap
    put_sample(4'd2, 1'b1, 16'd1000, 16'd1300, 32'hFFFF_FFFE);
    put_sample(4'd2, 1'b1, 16'd1000, 16'd1300, 32'hFFFF_FFFF);
    put_sample(4'd2, 1'b1, 16'd1000, 16'd1000, 32'd0);
    put_sample(4'd15, 1'b1, 16'd65535, 16'd65535, 32'hFFFF_FFFF);
    // truncated threshold at the largest settings
    drain();
    set_config(16'd65535, 16'd65535);
    put_sample(4'd15, 1'b1, 16'd65535, 16'd0, 32'd0);
    // zero threshold and zero window, equal ages
    drain();
    set_config(16'd0, 16'd0);
    put_sample(4'd4, 1'b1, 16'd500, 16'd600, 32'd100);
    put_sample(4'd4, 1'b1, 16'd500, 16'd599, 32'd100);
    put_sample(4'd4, 1'b1, 16'd500, 16'd598, 32'd101);

    now_ms = 32'd1000;
    for (int p = 0; p < 7; p++) begin
      drain();
      set_config(thr_set[p], win_set[p]);
      quiet = (p == 3);
      if (p == 4) now_ms = 32'hFFFF_FFC0;
      phase_end = n_samples + 100;
      while (n_samples < phase_end) touch_stroke();
    end
    quiet = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d samples over %0d register settings", n_samples, n_settings);
    $display("%0d results checked, %0d releases predicted", checked, releases);
    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
